// ===== rtl/core/lcd_shadow_diff_encoder_assert.svh =====
// Assertion macros shared by the display encoder modules.
`ifndef LCD_SHADOW_DIFF_ENCODER_ASSERT_SVH
`define LCD_SHADOW_DIFF_ENCODER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LSDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LSDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lsde_pkg.sv =====
// Shared constants, types and helper functions of the display encoder.
package lsde_pkg;

  localparam int FRAME_CELLS = 256;
  localparam int CELL_W      = $clog2(FRAME_CELLS);

  localparam logic [7:0] ESC_BYTE    = 8'h5C;
  localparam logic [7:0] CH_CURSOR   = 8'h63;
  localparam logic [7:0] CH_CTRL_LO  = 8'h31;
  localparam logic [7:0] CH_CTRL_HI  = 8'h32;
  localparam logic [7:0] CURSOR_BASE = 8'h80;

  localparam logic [8:0] CURSOR_STOP  = 9'd127;
  localparam logic [8:0] ROW_GAP_LO   = 9'd40;
  localparam logic [8:0] ROW_NEXT_LO  = 9'd64;
  localparam logic [8:0] ROW_GAP_HI   = 9'd168;
  localparam logic [8:0] ROW_NEXT_HI  = 9'd192;

  // Byte slots of one command run, sent in ascending order.
  localparam logic [2:0] IDX_SEL_ESC = 3'd0;
  localparam logic [2:0] IDX_SEL_CHR = 3'd1;
  localparam logic [2:0] IDX_CUR_ESC = 3'd2;
  localparam logic [2:0] IDX_CUR_CMD = 3'd3;
  localparam logic [2:0] IDX_CUR_POS = 3'd4;
  localparam logic [2:0] IDX_CHAR    = 3'd5;

  typedef struct packed {
    logic [2:0] start;
    logic [7:0] sel_byte;
    logic [6:0] cell_lo;
    logic [7:0] ch;
  } run_t;

  typedef struct packed {
    logic              en;
    logic [CELL_W-1:0] addr;
    logic [7:0]        data;
  } shadow_wr_t;

  // Cursor position after one character is written at the given cell.
  function automatic logic [8:0] cursor_advance(input logic [CELL_W-1:0] cell_idx);
    logic [8:0] pos;
    pos = {1'b0, cell_idx};
    if (pos != CURSOR_STOP) begin
      pos = pos + 9'd1;
    end
    if (pos == ROW_GAP_LO) begin
      pos = ROW_NEXT_LO;
    end
    if (pos == ROW_GAP_HI) begin
      pos = ROW_NEXT_HI;
    end
    return pos;
  endfunction

endpackage

// ===== rtl/core/lsde_shadow.sv =====
// Shadow copy of the frame: registered-read memory with per-entry valid bits.
module lsde_shadow import lsde_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [CELL_W-1:0] rd_addr,
  output logic [7:0]        rd_data,
  input  shadow_wr_t        wr
);

  logic [7:0]             mem [FRAME_CELLS];
  logic [FRAME_CELLS-1:0] written;
  logic [7:0]             rd_q;
  logic                   rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : 8'd0;

endmodule

// ===== rtl/core/lsde_emit.sv =====
// Output sequencer: sends one command run a byte per beat.
`include "lcd_shadow_diff_encoder_assert.svh"

module lsde_emit import lsde_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  run_t       run,
  output logic       free,
  output logic       byte_valid,
  input  logic       byte_ready,
  output logic [7:0] out_byte,
  output logic       run_last
);

  logic       busy;
  logic [2:0] idx;
  logic [7:0] sel_byte;
  logic [6:0] cell_lo;
  logic [7:0] ch;

  assign byte_valid = busy;
  assign run_last   = (idx == IDX_CHAR);
  assign free       = !busy || (run_last && byte_ready);

  always_comb begin
    unique case (idx)
      IDX_SEL_ESC: out_byte = ESC_BYTE;
      IDX_SEL_CHR: out_byte = sel_byte;
      IDX_CUR_ESC: out_byte = ESC_BYTE;
      IDX_CUR_CMD: out_byte = CH_CURSOR;
      IDX_CUR_POS: out_byte = CURSOR_BASE | {1'b0, cell_lo};
      IDX_CHAR:    out_byte = ch;
      default:     out_byte = ch;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= IDX_CHAR;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= run.start;
    end else if (busy && byte_ready) begin
      if (run_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sel_byte <= run.sel_byte;
      cell_lo  <= run.cell_lo;
      ch       <= run.ch;
    end
  end

  `LSDE_ASSERT_NOW(a_load_when_free, load, free, "run loaded over a run in progress")
  `LSDE_ASSERT_NEXT(a_run_ends, busy && run_last && byte_ready && !load, !byte_valid, "sequencer kept running after the last byte")
  `LSDE_ASSERT_NOW(a_idx_range, busy, idx <= IDX_CHAR, "byte slot out of range")

endmodule

// ===== rtl/core/lcd_shadow_diff_encoder.sv =====
// Top level of the shadow-difference encoder for a split 40x4 character display.
// Cells enter in scan order 0..255, one beat per cell, and passes repeat with no
// gap. Each cell is read from a shadow memory (registered read), compared, and on
// a change written back and turned into a run of 1, 4 or 6 output beats. The
// output sends one byte per cycle while byte_ready is high, an unchanged cell sends
// nothing, and the next cell is taken while a run is still going out. An input cell
// is registered into stage s1 along with its shadow read, and a run is registered
// into the output sequencer before its first byte goes out. The shadow clears at
// reset through per-entry valid bits, with no clearing pass.
`include "lcd_shadow_diff_encoder_assert.svh"

module lcd_shadow_diff_encoder import lsde_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cell_valid,
  output logic       cell_ready,
  input  logic [7:0] cell_char,
  output logic       byte_valid,
  input  logic       byte_ready,
  output logic [7:0] out_byte,
  output logic       run_last
);

  logic [CELL_W-1:0] scan_pos;
  logic              accept;

  logic              s1_valid;
  logic [CELL_W-1:0] s1_cell;
  logic [7:0]        s1_char;
  logic [7:0]        shadow_q;

  logic              cur_known;
  logic [8:0]        cur_pos;

  logic              changed;
  logic              eff_known;
  logic              hit;
  logic              need_sel;
  logic              em_free;
  logic              s1_go;
  run_t              run;
  shadow_wr_t        wr;

  assign accept     = cell_valid && cell_ready;
  assign cell_ready = !s1_valid || s1_go;

  lsde_shadow u_shadow (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (scan_pos),
    .rd_data (shadow_q),
    .wr      (wr)
  );

  // The cursor is forgotten at the start of every pass.
  assign changed   = (shadow_q != s1_char);
  assign eff_known = cur_known && (s1_cell != '0);
  assign hit       = eff_known && (cur_pos == {1'b0, s1_cell});
  assign need_sel  = !hit && (!eff_known || (s1_cell[CELL_W-1] != (cur_pos[8] | cur_pos[7])));
  assign s1_go     = s1_valid && (!changed || em_free);

  always_comb begin
    run.sel_byte = s1_cell[CELL_W-1] ? CH_CTRL_HI : CH_CTRL_LO;
    run.cell_lo  = s1_cell[6:0];
    run.ch       = s1_char;
    priority if (need_sel) begin
      run.start = IDX_SEL_ESC;
    end else if (!hit) begin
      run.start = IDX_CUR_ESC;
    end else begin
      run.start = IDX_CHAR;
    end
  end

  assign wr.en   = s1_go && changed;
  assign wr.addr = s1_cell;
  assign wr.data = s1_char;

  lsde_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (wr.en),
    .run        (run),
    .free       (em_free),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .out_byte   (out_byte),
    .run_last   (run_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pos  <= '0;
      s1_valid  <= 1'b0;
      cur_known <= 1'b0;
      cur_pos   <= '0;
    end else begin
      if (accept) begin
        scan_pos <= scan_pos + 1'b1;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        if (changed) begin
          cur_known <= 1'b1;
          cur_pos   <= cursor_advance(s1_cell);
        end else if (s1_cell == '0) begin
          cur_known <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cell <= scan_pos;
      s1_char <= cell_char;
    end
  end

  `LSDE_ASSERT_NOW(a_no_same_entry, wr.en && accept, wr.addr != scan_pos, "shadow read and write hit the same entry")
  `LSDE_ASSERT_NOW(a_cursor_skips_gap, cur_known, cur_pos != ROW_GAP_LO && cur_pos != ROW_GAP_HI, "cursor stopped in a row gap")
  `LSDE_ASSERT_NOW(a_hit_char_only, wr.en && hit, run.start == IDX_CHAR, "cursor hit still sends a cursor command")

endmodule
